/* design/normalized_value_histogram_macros.svh */
// Assertion macros for the normalised value histogram block.
`ifndef NORMALIZED_VALUE_HISTOGRAM_MACROS_SVH
`define NORMALIZED_VALUE_HISTOGRAM_MACROS_SVH

`ifndef SYNTHESIS

// Check that ante implies cons in the same cycle
`define NVH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that ante implies cons in the next cycle
`define NVH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define NVH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define NVH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* design/nvh_pkg.sv */
// Shared types and constants of the normalised value histogram.
`default_nettype none

package nvh_pkg;

    // Sizing
    localparam int BIN_COUNT   = 64;
    localparam int COUNT_WIDTH = 16;
    localparam int BIN_W       = $clog2(BIN_COUNT);
    localparam int VALUE_W     = 6;
    localparam int FRAC_W      = 17;
    localparam int STEP_W      = $clog2(FRAC_W);

    // Input transaction
    typedef struct packed {
        logic [VALUE_W-1:0] sample_value;
        logic               list_end;
    } nvh_in_t;

    // Output transaction
    typedef struct packed {
        logic [VALUE_W-1:0] bin_index;
        logic [FRAC_W-1:0]  bin_fraction;
        logic               final_bin;
    } nvh_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic bump;
        logic init_div;
        logic div_step;
        logic emit;
        logic next_bin;
        logic clear_list;
    } nvh_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic list_end;
        logic div_done;
        logic slot_free;
        logic last_bin;
    } nvh_sts_t;

endpackage

`default_nettype wire

/* design/nvh_ctrl.sv */
// Sequencing state machine of the normalised value histogram.
`default_nettype none

module nvh_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire nvh_pkg::nvh_sts_t sts,
    output nvh_pkg::nvh_cmd_t      cmd
);
    import nvh_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BUMP = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_INIT = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_PUT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Decode next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_BUMP;
                end
            end
            ST_BUMP:
            begin
                cmd.bump   = 1'b1;
                state_next = sts.list_end ? ST_READ : ST_IDLE;
            end
            ST_READ:
                state_next = ST_INIT;
            ST_INIT:
            begin
                cmd.init_div = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.last_bin)
                    begin
                        cmd.clear_list = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        cmd.next_bin = 1'b1;
                        state_next   = ST_READ;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* design/nvh_dpath.sv */
// Count store, list registers, bit-serial divider and output register.
`default_nettype none

module nvh_dpath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire nvh_pkg::nvh_in_t  in_item,
    input  wire nvh_pkg::nvh_cmd_t cmd,
    output nvh_pkg::nvh_sts_t      sts,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output nvh_pkg::nvh_out_t      out_item
);
    import nvh_pkg::*;

    logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];
    logic [BIN_COUNT-1:0]   bin_valid_reg;

    logic [BIN_W-1:0]       val_reg;
    logic                   last_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_valid_reg;
    logic [COUNT_WIDTH-1:0] items_reg;
    logic [BIN_W-1:0]       largest_reg;
    logic [BIN_W-1:0]       bin_reg;
    logic [COUNT_WIDTH:0]   rem_reg;
    logic [FRAC_W-1:0]      quo_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   out_valid_reg;
    nvh_out_t               out_item_reg;

    logic [BIN_W-1:0]       in_bin;
    logic [BIN_W-1:0]       rd_addr;
    logic [COUNT_WIDTH-1:0] cur_cnt;
    logic [COUNT_WIDTH-1:0] new_cnt;
    logic [COUNT_WIDTH:0]   shifted;
    logic [COUNT_WIDTH:0]   divisor;
    logic                   ge;

    // Saturate out-of-range values into the top bin
    assign in_bin = ({1'b0, in_item.sample_value} >= (VALUE_W+1)'(BIN_COUNT))
                    ? BIN_W'(BIN_COUNT - 1) : BIN_W'(in_item.sample_value);

    assign rd_addr = cmd.capture ? in_bin : bin_reg;

    // Saturating increment of the stored count
    assign cur_cnt = rd_valid_reg ? rd_data_reg : '0;
    assign new_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;

    // Count store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.bump)
            mem[val_reg] <= new_cnt;
        rd_data_reg <= mem[rd_addr];
    end

    // Entry valid flags and registered flag read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= bin_valid_reg[rd_addr];
            if (cmd.clear_list)
                bin_valid_reg <= '0;
            else if (cmd.bump)
                bin_valid_reg[val_reg] <= 1'b1;
        end
    end

    // Capture the incoming transaction
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            val_reg  <= in_bin;
            last_reg <= in_item.list_end;
        end
    end

    // List totals: item count and largest value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_reg   <= '0;
            largest_reg <= '0;
        end
        else if (cmd.clear_list)
        begin
            items_reg   <= '0;
            largest_reg <= '0;
        end
        else if (cmd.bump)
        begin
            if (items_reg != '1)
                items_reg <= items_reg + 1'b1;
            if (val_reg > largest_reg)
                largest_reg <= val_reg;
        end
    end

    // Bin walk pointer
    always_ff @(posedge clk)
    begin
        if (cmd.bump)
            bin_reg <= '0;
        else if (cmd.next_bin)
            bin_reg <= bin_reg + 1'b1;
    end

    // One quotient bit per step; the first step tests the integer bit unshifted
    assign divisor = {1'b0, items_reg};
    assign shifted = (step_reg == '0) ? rem_reg : {rem_reg[COUNT_WIDTH-1:0], 1'b0};
    assign ge      = (shifted >= divisor);

    always_ff @(posedge clk)
    begin
        if (cmd.init_div)
        begin
            rem_reg  <= {1'b0, cur_cnt};
            quo_reg  <= '0;
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= ge ? shifted - divisor : shifted;
            quo_reg  <= {quo_reg[FRAC_W-2:0], ge};
            step_reg <= step_reg + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_item_reg.bin_index    <= VALUE_W'(bin_reg);
            out_item_reg.bin_fraction <= quo_reg;
            out_item_reg.final_bin    <= (bin_reg == largest_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Status back to the controller
    assign sts.list_end  = last_reg;
    assign sts.div_done  = (step_reg == STEP_W'(FRAC_W - 1));
    assign sts.slot_free = !out_valid_reg || out_ready;
    assign sts.last_bin  = (bin_reg == largest_reg);

endmodule

`default_nettype wire

/* design/normalized_value_histogram.sv */
// Top level of the normalised value histogram.
//
// Values are counted into per-bin counters held in a simple dual-port count store;
// each input transaction is accepted, and its bin is then read, modified and written
// back through the store's one read and one write port. When the item flagged as
// list end has been counted, the block walks the bins from 0 up to the largest
// value seen and emits floor(count * 65536 / total) in unsigned Q1.16 for each;
// each bin passes through a store read, a divider load, 17 steps of the bit-serial
// restoring divider and an output load, and waits while the output is stalled.
// No input is accepted during the walk. Counters, largest value and item count
// clear when the marked last result is loaded; the store itself is cleared
// through per-entry valid flags, so no clearing pass runs.
`default_nettype none
`include "normalized_value_histogram_macros.svh"

module normalized_value_histogram (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire nvh_pkg::nvh_in_t  in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output nvh_pkg::nvh_out_t      out_item
);
    import nvh_pkg::*;

    nvh_cmd_t cmd;
    nvh_sts_t sts;

    // Sequencer
    nvh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath
    nvh_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // An accepted transaction blocks the input while its bin is updated
    `NVH_ASSERT_NXT(a_accept_blocks, clk, rst_n, in_valid && in_ready, !in_ready, "input not blocked after accept")

    // A result is only loaded into a free output slot
    `NVH_ASSERT_IMP(a_emit_slot, clk, rst_n, cmd.emit, !out_valid || out_ready, "result overwrote pending output")

    // Loading the final bin ends the walk and reopens the input
    `NVH_ASSERT_NXT(a_final_reopens, clk, rst_n, cmd.emit && sts.last_bin, in_ready && out_valid && out_item.final_bin, "walk did not end on final bin")

    // The list is cleared only together with its final result
    `NVH_ASSERT_IMP(a_clear_final, clk, rst_n, cmd.clear_list, cmd.emit && sts.last_bin, "list cleared before final result")

endmodule

`default_nettype wire
